@@ design/skt_pkg.sv @@
// skt_pkg: shared constants, codes, request/response types and the cell control
// type for the sorted key table. No dependencies.
package skt_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 32;
  localparam int POS_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_FIND   = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BADPOS   = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [7:0]  position;
  } skt_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] index;
    logic [8:0] count;
  } skt_rsp_t;

  typedef struct packed {
    logic                capture;
    logic                ins;
    logic                del;
    logic                cmp_signed;
    logic [CNT_BITS-1:0] count;
    logic [POS_BITS-1:0] pos;
    logic [KEY_BITS-1:0] want;
    logic [KEY_BITS-1:0] new_key;
  } skt_cell_ctrl_t;

endpackage

@@ design/skt_cell.sv @@
// skt_cell: one table slot, holds a key and its compare flags.
// Depends on skt_pkg.
module skt_cell (
  input  logic                          clk_i,
  input  skt_pkg::skt_cell_ctrl_t       ctrl_i,
  input  logic [skt_pkg::POS_BITS-1:0]  cell_idx_i,
  input  logic [skt_pkg::KEY_BITS-1:0]  left_key_i,
  input  logic [skt_pkg::KEY_BITS-1:0]  right_key_i,
  output logic [skt_pkg::KEY_BITS-1:0]  key_o,
  output logic                          lt_o,
  output logic                          eq_o
);

  logic [skt_pkg::KEY_BITS-1:0] key_q;
  logic [skt_pkg::KEY_BITS-1:0] have;
  logic                         lt_q;
  logic                         eq_q;
  logic                         occupied;

  assign have     = key_q ^ {ctrl_i.cmp_signed, {(skt_pkg::KEY_BITS - 1){1'b0}}};
  assign occupied = {1'b0, cell_idx_i} < ctrl_i.count;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      lt_q <= occupied & (have < ctrl_i.want);
      eq_q <= occupied & (have == ctrl_i.want);
    end
  end

  // insert opens a slot at the search position, delete closes one
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && (cell_idx_i >= ctrl_i.pos)) begin
      key_q <= (cell_idx_i == ctrl_i.pos) ? ctrl_i.new_key : left_key_i;
    end else if (ctrl_i.del && (cell_idx_i >= ctrl_i.pos)) begin
      key_q <= right_key_i;
    end
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

@@ design/skt_chain.sv @@
// skt_chain: row of skt_cell slots wired to their neighbors.
// Depends on skt_pkg and skt_cell.
module skt_chain (
  input  logic                          clk_i,
  input  skt_pkg::skt_cell_ctrl_t       ctrl_i,
  output logic [skt_pkg::CAPACITY-1:0]  lt_o,
  output logic [skt_pkg::CAPACITY-1:0]  eq_o
);

  logic [skt_pkg::KEY_BITS-1:0] keys [skt_pkg::CAPACITY];

  for (genvar i = 0; i < skt_pkg::CAPACITY; i++) begin : g_cell
    logic [skt_pkg::KEY_BITS-1:0] left_key;
    logic [skt_pkg::KEY_BITS-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key = '0;
    end else begin : g_mid
      assign left_key = keys[i-1];
    end

    if (i == skt_pkg::CAPACITY - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_next
      assign right_key = keys[i+1];
    end

    skt_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .cell_idx_i  (skt_pkg::POS_BITS'(i)),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .key_o       (keys[i]),
      .lt_o        (lt_o[i]),
      .eq_o        (eq_o[i])
    );
  end

endmodule

@@ design/sorted_key_table.sv @@
// sorted_key_table: ordered key table with insert, find, delete and clear.
// The accept edge latches compare flags in every cell; insert and find then probe
// one cell per cycle in binary search order, at most 9 probes for 256 entries.
// Delete, clear and a search of an empty table need no probe. The response is
// registered at completion; no request is accepted until the previous one completes.
// A held response stalls completion. Reset clears the entry count, the compare mode
// and the handshake state; key storage is not cleared.
// Depends on skt_pkg and skt_chain.
module sorted_key_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  skt_pkg::skt_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output skt_pkg::skt_rsp_t out_rsp_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic                         state_q, state_d;
  logic                         cmp_signed_q;
  logic [skt_pkg::CNT_BITS-1:0] count_q, count_d;
  skt_pkg::skt_req_t            req_q;
  skt_pkg::skt_rsp_t            rsp_q, rsp_d;
  logic                         out_valid_q, out_valid_d;
  skt_pkg::skt_cell_ctrl_t      ctrl;
  logic [skt_pkg::CAPACITY-1:0] lt_vec;
  logic [skt_pkg::CAPACITY-1:0] eq_vec;
  logic                         in_fire;
  logic                         done;
  logic                         full;
  logic                         pos_ok;
  logic                         seek;
  logic [skt_pkg::CNT_BITS-1:0] lo_q, hi_q;
  logic [skt_pkg::CNT_BITS-1:0] lo_n, hi_n;
  logic [skt_pkg::CNT_BITS-1:0] mid;
  logic [skt_pkg::CNT_BITS-1:0] where;
  logic                         probe;
  logic                         probe_lt;
  logic                         probe_eq;
  logic                         hit;
  logic                         search_end;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign seek        = (req_q.func == skt_pkg::FUNC_INSERT) |
                       (req_q.func == skt_pkg::FUNC_FIND);
  assign done        = (state_q == S_BUSY) & (~seek | search_end) &
                       (~out_valid_q | out_ready_i);

  assign full   = count_q >= skt_pkg::CNT_BITS'(skt_pkg::CAPACITY);
  assign pos_ok = {1'b0, req_q.position} < count_q;

  // one binary search probe per cycle over the latched flags
  always_comb begin
    probe    = lo_q < hi_q;
    mid      = lo_q + ((hi_q - lo_q) >> 1);
    probe_lt = lt_vec[mid[skt_pkg::POS_BITS-1:0]];
    probe_eq = eq_vec[mid[skt_pkg::POS_BITS-1:0]];
    hit      = probe & probe_eq;
    lo_n     = lo_q;
    hi_n     = hi_q;
    if (probe && !probe_eq) begin
      if (probe_lt) begin
        lo_n = mid + 1'b1;
      end else begin
        hi_n = mid;
      end
    end
    where      = hit ? mid : lo_n;
    search_end = ~probe | hit | (lo_n >= hi_n);
  end

  always_comb begin
    ctrl.capture    = in_fire;
    ctrl.ins        = done & (req_q.func == skt_pkg::FUNC_INSERT) & ~hit & ~full;
    ctrl.del        = done & (req_q.func == skt_pkg::FUNC_DELETE) & pos_ok;
    ctrl.cmp_signed = cmp_signed_q;
    ctrl.count      = count_q;
    ctrl.pos        = (req_q.func == skt_pkg::FUNC_INSERT) ?
                      where[skt_pkg::POS_BITS-1:0] : req_q.position;
    ctrl.want       = in_req_i.key ^ {cmp_signed_q, {(skt_pkg::KEY_BITS - 1){1'b0}}};
    ctrl.new_key    = req_q.key;
  end

  skt_chain u_chain (
    .clk_i (clk_i),
    .ctrl_i(ctrl),
    .lt_o  (lt_vec),
    .eq_o  (eq_vec)
  );

  always_comb begin
    count_d      = count_q;
    rsp_d        = rsp_q;
    rsp_d.status = skt_pkg::ST_OK;
    rsp_d.index  = where;
    unique case (req_q.func)
      skt_pkg::FUNC_INSERT: begin
        if (hit) begin
          rsp_d.status = skt_pkg::ST_DUP;
        end else if (full) begin
          rsp_d.status = skt_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      skt_pkg::FUNC_FIND: begin
        if (!hit) begin
          rsp_d.status = skt_pkg::ST_NOTFOUND;
        end
      end
      skt_pkg::FUNC_DELETE: begin
        rsp_d.index = {1'b0, req_q.position};
        if (pos_ok) begin
          count_d = count_q - 1'b1;
        end else begin
          rsp_d.status = skt_pkg::ST_BADPOS;
        end
      end
      default: begin
        count_d     = '0;
        rsp_d.index = '0;
      end
    endcase
    rsp_d.count = count_d;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_BUSY;
        end
      end
      default: begin
        if (done) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      cmp_signed_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (done) begin
        count_q <= count_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cmp_signed_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_req_i;
      lo_q  <= '0;
      hi_q  <= count_q;
    end else if ((state_q == S_BUSY) && !search_end) begin
      lo_q <= lo_n;
      hi_q <= hi_n;
    end
    if (done) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= skt_pkg::CNT_BITS'(skt_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUSY) |-> (lo_q <= hi_q))
    else $error("search bounds crossed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_BUSY))
    else $error("accepted request did not enter busy state");

  a_rsp_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (out_valid_q && (rsp_q.count == count_q)))
    else $error("response missing or count mismatch after completion");

endmodule

@@ test/skt_checker.sv @@
// skt_checker: watches the request, response and config channels of
// sorted_key_table, predicts every response and compares it field by field.
// Depends on skt_pkg.
`timescale 1ns / 1ps
module skt_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  skt_pkg::skt_req_t in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  skt_pkg::skt_rsp_t out_rsp_i,
  output int                pending_o,
  output int                fail_count_o
);

  logic [skt_pkg::KEY_BITS-1:0] key_store [skt_pkg::CAPACITY];
  logic [skt_pkg::CNT_BITS-1:0] held;
  logic                         signed_order;
  skt_pkg::skt_rsp_t            expected_rsp [$];
  int                           mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic [skt_pkg::KEY_BITS-1:0] order_of(
      logic [skt_pkg::KEY_BITS-1:0] k);
    return signed_order ? {~k[skt_pkg::KEY_BITS-1], k[skt_pkg::KEY_BITS-2:0]} : k;
  endfunction

  // binary search over held entries, match position or insertion point
  function automatic logic locate(input logic [skt_pkg::KEY_BITS-1:0] k,
                                  output int where);
    int                           lo;
    int                           hi;
    int                           mid;
    logic [skt_pkg::KEY_BITS-1:0] want;
    lo   = 0;
    hi   = held;
    want = order_of(k);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (want < order_of(key_store[mid])) begin
        hi = mid;
      end else if (want > order_of(key_store[mid])) begin
        lo = mid + 1;
      end else begin
        where = mid;
        return 1'b1;
      end
    end
    where = lo;
    return 1'b0;
  endfunction

  function automatic skt_pkg::skt_rsp_t apply_request(skt_pkg::skt_req_t r);
    skt_pkg::skt_rsp_t rsp;
    int                where;
    int                i;
    rsp.status = skt_pkg::ST_OK;
    rsp.index  = '0;
    case (r.func)
      skt_pkg::FUNC_INSERT: begin
        if (locate(r.key, where)) begin
          rsp.status = skt_pkg::ST_DUP;
        end else if (held >= skt_pkg::CAPACITY) begin
          rsp.status = skt_pkg::ST_FULL;
        end else begin
          for (i = held; i > where; i--) key_store[i] = key_store[i-1];
          key_store[where] = r.key;
          held++;
        end
        rsp.index = where[8:0];
      end
      skt_pkg::FUNC_FIND: begin
        if (!locate(r.key, where)) rsp.status = skt_pkg::ST_NOTFOUND;
        rsp.index = where[8:0];
      end
      skt_pkg::FUNC_DELETE: begin
        rsp.index = {1'b0, r.position};
        if (r.position >= held) begin
          rsp.status = skt_pkg::ST_BADPOS;
        end else begin
          for (i = r.position; i + 1 < held; i++) key_store[i] = key_store[i+1];
          held--;
        end
      end
      default: begin
        held = '0;
      end
    endcase
    rsp.count = held;
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    skt_pkg::skt_rsp_t oldest;
    if (!rst_ni) begin
      held         = '0;
      signed_order = 1'b0;
      expected_rsp.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          $error("response with no request outstanding: status %0d index %0d count %0d",
                 out_rsp_i.status, out_rsp_i.index, out_rsp_i.count);
          mismatches++;
        end else begin
          oldest = expected_rsp.pop_front();
          if (out_rsp_i.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_rsp_i.status);
            mismatches++;
          end
          if (out_rsp_i.index !== oldest.index) begin
            $error("index: expected %0d, got %0d", oldest.index, out_rsp_i.index);
            mismatches++;
          end
          if (out_rsp_i.count !== oldest.count) begin
            $error("count: expected %0d, got %0d", oldest.count, out_rsp_i.count);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) signed_order = cfg_data_i;
      if (in_valid_i && in_ready_i) expected_rsp.push_back(apply_request(in_req_i));
      pending_o <= expected_rsp.size();
    end
  end

endmodule

@@ test/tb.sv @@
// tb: drives sorted_key_table with directed and random requests in both
// compare modes under several idling patterns, and gives the verdict.
// Depends on skt_pkg, sorted_key_table and skt_checker.
`timescale 1ns / 1ps
module tb;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  skt_pkg::skt_req_t in_req_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  skt_pkg::skt_rsp_t out_rsp_o;

  int pending;
  int fail_count;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  logic [skt_pkg::KEY_BITS-1:0] key_base = '0;

  sorted_key_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  skt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_i    (out_rsp_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic issue(logic [1:0] func, logic [31:0] key, logic [7:0] position);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_req_i.func     <= func;
    in_req_i.key      <= key;
    in_req_i.position <= position;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // clear takes whatever share the other three leave
  task automatic random_request(int ins_pct, int find_pct, int del_pct, int pool_pct,
                                int near_pct);
    int          roll;
    logic [1:0]  func;
    logic [31:0] key;
    logic [7:0]  position;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) func = skt_pkg::FUNC_INSERT;
    else if (roll < ins_pct + find_pct) func = skt_pkg::FUNC_FIND;
    else if (roll < ins_pct + find_pct + del_pct) func = skt_pkg::FUNC_DELETE;
    else func = skt_pkg::FUNC_CLEAR;
    key = ($urandom_range(0, 99) < pool_pct) ? key_base + $urandom_range(0, 47) : $urandom;
    position = ($urandom_range(0, 99) < near_pct) ? 8'($urandom_range(0, 47)) : 8'($urandom);
    issue(func, key, position);
  endtask

  initial begin
    int p;
    int n;
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 1'b0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, extreme keys, duplicate, hits, misses, bad positions
    issue(skt_pkg::FUNC_FIND,   32'h0000_0000, 8'd0);
    issue(skt_pkg::FUNC_DELETE, 32'h0000_0000, 8'd0);
    issue(skt_pkg::FUNC_INSERT, 32'h0000_0000, 8'd0);
    issue(skt_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 8'd255);
    issue(skt_pkg::FUNC_INSERT, 32'h8000_0000, 8'd0);
    issue(skt_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 8'd0);
    issue(skt_pkg::FUNC_INSERT, 32'h0000_0000, 8'd0);
    issue(skt_pkg::FUNC_FIND,   32'h8000_0000, 8'd0);
    issue(skt_pkg::FUNC_FIND,   32'h1234_5678, 8'd0);
    issue(skt_pkg::FUNC_DELETE, 32'h0000_0000, 8'd255);
    issue(skt_pkg::FUNC_DELETE, 32'h0000_0000, 8'd4);
    issue(skt_pkg::FUNC_DELETE, 32'h0000_0000, 8'd1);
    issue(skt_pkg::FUNC_DELETE, 32'hFFFF_FFFF, 8'd0);
    issue(skt_pkg::FUNC_CLEAR,  32'hFFFF_FFFF, 8'd255);
    issue(skt_pkg::FUNC_FIND,   32'hFFFF_FFFF, 8'd0);
    drain();
    write_cfg(1'b1);
    issue(skt_pkg::FUNC_INSERT, 32'h8000_0000, 8'd0);
    issue(skt_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 8'd0);
    issue(skt_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 8'd0);
    issue(skt_pkg::FUNC_INSERT, 32'h0000_0001, 8'd0);
    issue(skt_pkg::FUNC_FIND,   32'hFFFF_FFFF, 8'd0);
    issue(skt_pkg::FUNC_FIND,   32'h0000_0000, 8'd0);
    issue(skt_pkg::FUNC_DELETE, 32'h0000_0000, 8'd3);
    issue(skt_pkg::FUNC_INSERT, 32'h8000_0001, 8'd0);

    // mode switches with entries left in the table are part of the run
    for (p = 0; p < 6; p++) begin
      drain();
      write_cfg(p[0]);
      case (p % 4)
        0: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_gap_pct   = 68;
          rx_stall_pct = 0;
        end
        2: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 68;
        end
        default: begin
          tx_gap_pct   = 24;
          rx_stall_pct = 24;
        end
      endcase
      if (p == 1 || p == 4) begin
        // fill to capacity, then work on a full table
        issue(skt_pkg::FUNC_CLEAR, $urandom, 8'($urandom));
        for (n = 0; n < 275; n++) random_request(96, 4, 0, 0, 0);
        for (n = 0; n < 65; n++) random_request(40, 20, 40, 30, 0);
      end else begin
        for (n = 0; n < 270; n++) begin
          if (n % 48 == 0) begin
            case ($urandom_range(0, 3))
              0:       key_base = 32'h0000_0000;
              1:       key_base = 32'h7FFF_FFE8;
              2:       key_base = 32'hFFFF_FFE8;
              default: key_base = $urandom;
            endcase
          end
          random_request(40, 25, 32, 60, 70);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
